@@ rtl/tscf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the token sentence candidate filter.
// Holds request codes, the cell control struct and default sizes; no dependencies.
package tscf_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int MAX_TOKENS_DEF  = 16;
  localparam int TOKEN_BITS_DEF  = 16;

  localparam int IDX_W  = 6;
  localparam int WPOS_W = 4;
  localparam int LEN_W  = 5;
  localparam int TOK_W  = 16;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FIRST = 2'd1,
    REQ_NEXT  = 2'd2,
    REQ_END   = 2'd3
  } req_t;

  typedef struct packed {
    req_t req;
    logic we;
    logic clr;
  } cell_ctl_t;

endpackage

@@ rtl/tscf_cell.sv @@
`timescale 1ns / 1ps
// One table entry of the candidate filter: token store, length, valid and candidate bits.
// Depends on tscf_pkg; instantiated in a chain by the top level.
module tscf_cell #(
  parameter int E           = 0,
  parameter int NUM_ENTRIES = tscf_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_TOKENS  = tscf_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_BITS  = tscf_pkg::TOKEN_BITS_DEF,
  localparam int PW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int LW  = $clog2(MAX_TOKENS + 1),
  localparam int PSW = $clog2(MAX_TOKENS + 2),
  localparam int CW  = $clog2(NUM_ENTRIES + 1),
  localparam int IW  = $clog2(NUM_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tscf_pkg::cell_ctl_t        ctl,
  input  logic [tscf_pkg::IDX_W-1:0] ld_idx,
  input  logic [tscf_pkg::WPOS_W-1:0] ld_pos,
  input  logic [LW-1:0]              ld_len,
  input  logic [TOKEN_BITS-1:0]      tok,
  input  logic [PW-1:0]              rd_addr,
  input  logic [PSW-1:0]             pos,
  input  logic                       go_in,
  input  logic [CW-1:0]              cnt_in,
  input  logic [IW-1:0]              last_in,
  output logic                       go_out,
  output logic [CW-1:0]              cnt_out,
  output logic [IW-1:0]              last_out
);

  logic [TOKEN_BITS-1:0] mem [MAX_TOKENS];
  logic [TOKEN_BITS-1:0] rd_r;
  logic [LW-1:0]         len_r;
  logic                  valid_r;
  logic                  cand_r;
  logic                  go_r;
  logic [CW-1:0]         cnt_r;
  logic [IW-1:0]         last_r;
  logic                  sel;
  logic                  hit;

  assign sel = (int'(ld_idx) == E);

  always_comb begin
    unique case (ctl.req)
      tscf_pkg::REQ_FIRST: hit = valid_r && (len_r != '0) && (rd_r == tok);
      tscf_pkg::REQ_NEXT:  hit = cand_r && (int'(len_r) > int'(pos)) && (rd_r == tok);
      tscf_pkg::REQ_END:   hit = cand_r && (int'(len_r) == int'(pos));
      default:             hit = cand_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.we && sel && (int'(ld_pos) < MAX_TOKENS)) begin
      mem[PW'(ld_pos)] <= tok;
    end
    rd_r <= mem[rd_addr];
    if (ctl.we && sel) begin
      len_r <= ld_len;
    end
    cnt_r  <= CW'(cnt_in + CW'(hit));
    last_r <= hit ? IW'(E) : last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      go_r <= go_in;
      if (ctl.we && sel) begin
        valid_r <= 1'b1;
      end
      if (ctl.clr) begin
        cand_r <= 1'b0;
      end else if (go_in) begin
        cand_r <= hit;
      end
    end
  end

  assign go_out   = go_r;
  assign cnt_out  = cnt_r;
  assign last_out = last_r;

endmodule

@@ rtl/token_sentence_candidate_filter_core.sv @@
`timescale 1ns / 1ps
// Top level of the token sentence candidate filter: control sequencer, chain of entry cells
// and output register. Depends on tscf_pkg and tscf_cell.

// Items are handled one at a time. A load transfer writes one token word and the entry
// length into its cell, then passes through the write and finish states to the output
// register. A first-token, next-token or end transfer reads the token at the current
// position in every cell, then sends a count and last-hit index down the chain of
// NUM_ENTRIES cells, one cell per cycle, before its result goes to the output register.
// A finished result waits in the output register, and a new input transfer is
// taken as soon as the sequencer is back in its idle state.
module token_sentence_candidate_filter_core #(
  parameter int NUM_ENTRIES = tscf_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_TOKENS  = tscf_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_BITS  = tscf_pkg::TOKEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[5:0], word_pos[9:6], entry_length[14:10], token[30:15], zero[31]
  input  logic [31:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[0], match_found[1], match_index[7:2], candidate_count[14:8], zero[15]
  output logic [15:0] out_tdata
);

  localparam int PW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int LW  = $clog2(MAX_TOKENS + 1);
  localparam int PSW = $clog2(MAX_TOKENS + 2);
  localparam int CW  = $clog2(NUM_ENTRIES + 1);
  localparam int IW  = $clog2(NUM_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_LAUNCH,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t                      state_r;
  tscf_pkg::req_t              req_r;
  logic [tscf_pkg::IDX_W-1:0]  idx_r;
  logic [tscf_pkg::WPOS_W-1:0] wpos_r;
  logic [LW-1:0]               len_r;
  logic [TOKEN_BITS-1:0]       tok_r;
  logic [PSW-1:0]              pos_r;
  logic [CW-1:0]               left_r;
  logic                        res_status_r;
  logic                        res_found_r;
  logic [tscf_pkg::IDX_W-1:0]  res_idx_r;
  logic [tscf_pkg::CNT_W-1:0]  res_cnt_r;
  logic                        clr_r;
  logic                        out_tvalid_r;
  logic [15:0]                 out_tdata_r;

  logic                        in_fire;
  logic                        out_free;
  tscf_pkg::req_t              in_req;
  logic [tscf_pkg::LEN_W-1:0]  in_len;
  logic [tscf_pkg::TOK_W-1:0]  in_tok;
  logic [LW-1:0]               in_len_sat;
  tscf_pkg::cell_ctl_t         ctl;
  logic [PW-1:0]               rd_addr;
  logic [CW-1:0]               tail_cnt;
  logic [IW-1:0]               tail_last;

  logic          go_c   [NUM_ENTRIES+1];
  logic [CW-1:0] cnt_c  [NUM_ENTRIES+1];
  logic [IW-1:0] last_c [NUM_ENTRIES+1];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign in_req     = tscf_pkg::req_t'(in_tuser);
  assign in_len     = in_tdata[14:10];
  assign in_tok     = in_tdata[30:15];
  assign in_len_sat = (int'(in_len) > MAX_TOKENS) ? LW'(MAX_TOKENS) : LW'(in_len);

  assign ctl.req = req_r;
  assign ctl.we  = (state_r == ST_WRITE);
  assign ctl.clr = (state_r == ST_FIN) && clr_r;

  always_comb begin
    if ((req_r == tscf_pkg::REQ_FIRST) || (int'(pos_r) >= MAX_TOKENS)) begin
      rd_addr = '0;
    end else begin
      rd_addr = PW'(pos_r);
    end
  end

  assign go_c[0]   = (state_r == ST_LAUNCH);
  assign cnt_c[0]  = '0;
  assign last_c[0] = '0;
  assign tail_cnt  = cnt_c[NUM_ENTRIES];
  assign tail_last = last_c[NUM_ENTRIES];

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_cell
    tscf_cell #(
      .E          (e),
      .NUM_ENTRIES(NUM_ENTRIES),
      .MAX_TOKENS (MAX_TOKENS),
      .TOKEN_BITS (TOKEN_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .ld_idx  (idx_r),
      .ld_pos  (wpos_r),
      .ld_len  (len_r),
      .tok     (tok_r),
      .rd_addr (rd_addr),
      .pos     (pos_r),
      .go_in   (go_c[e]),
      .cnt_in  (cnt_c[e]),
      .last_in (last_c[e]),
      .go_out  (go_c[e+1]),
      .cnt_out (cnt_c[e+1]),
      .last_out(last_c[e+1])
    );
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_req;
      idx_r  <= in_tdata[5:0];
      wpos_r <= in_tdata[9:6];
      len_r  <= in_len_sat;
      tok_r  <= TOKEN_BITS'(in_tok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      left_r       <= '0;
      clr_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      res_status_r <= 1'b0;
      res_found_r  <= 1'b0;
      res_idx_r    <= '0;
      res_cnt_r    <= '0;
      out_tdata_r  <= '0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= (in_req == tscf_pkg::REQ_LOAD) ? ST_WRITE : ST_READ;
          end
        end
        ST_WRITE: begin
          res_status_r <= 1'b0;
          res_found_r  <= 1'b0;
          res_idx_r    <= '0;
          res_cnt_r    <= tscf_pkg::CNT_W'(left_r);
          clr_r        <= 1'b0;
          state_r      <= ST_FIN;
        end
        ST_READ: begin
          state_r <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          if (go_c[NUM_ENTRIES]) begin
            state_r <= ST_FIN;
            unique case (req_r)
              tscf_pkg::REQ_END: begin
                if (tail_cnt == CW'(1)) begin
                  res_status_r <= 1'b0;
                  res_found_r  <= 1'b1;
                  res_idx_r    <= tscf_pkg::IDX_W'(tail_last);
                  res_cnt_r    <= tscf_pkg::CNT_W'(1);
                  left_r       <= CW'(1);
                  clr_r        <= 1'b0;
                end else begin
                  res_status_r <= 1'b1;
                  res_found_r  <= 1'b0;
                  res_idx_r    <= '0;
                  res_cnt_r    <= '0;
                  left_r       <= '0;
                  clr_r        <= 1'b1;
                end
              end
              default: begin
                res_status_r <= (tail_cnt == '0);
                res_found_r  <= 1'b0;
                res_idx_r    <= '0;
                res_cnt_r    <= tscf_pkg::CNT_W'(tail_cnt);
                left_r       <= tail_cnt;
                clr_r        <= 1'b0;
                if (req_r == tscf_pkg::REQ_FIRST) begin
                  pos_r <= PSW'(1);
                end else if (int'(pos_r) < MAX_TOKENS + 1) begin
                  pos_r <= PSW'(pos_r + PSW'(1));
                end
              end
            endcase
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, res_cnt_r, res_idx_r, res_found_r, res_status_r};
            clr_r        <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/tscf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the token sentence candidate filter and its bind statement.
// Depends only on the top-level ports of token_sentence_candidate_filter_core.
module tscf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed or dropped while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken again before the previous transfer finished.");

  a_match_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0] && (out_tdata[14:8] == 7'd1))
    else $error("Match reported without exactly one candidate.");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[14:8] == 7'd0) && !out_tdata[1])
    else $error("No-candidate status with a nonzero count.");

endmodule

bind token_sentence_candidate_filter_core tscf_checker u_tscf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
